// File: rtl/snts_pkg.sv
// shared constants and types of the sorted name table search unit
package snts_pkg;

  localparam int TableDepthDef = 256;
  localparam int NameBytesDef  = 100;
  localparam int KeyW          = 63;
  localparam int StatW         = 2;

  // result status codes
  localparam logic [StatW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatW-1:0] ST_FOUND     = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  // compare unit answer: order of the collected name against a table row
  typedef struct packed {
    logic done;
    logic lt;
    logic gt;
  } cmp_rsp_t;

endpackage

// File: rtl/sorted_name_table_search_unit.sv
// top level: name collection, order table, keys and search sequencer
// sequence: name beats are taken while idle; after the last beat the name is zero
// padded, then a dispatch state follows, where an insert into a full table
// answers; each probe reads the order table, then compares the name byte by byte,
// log2(entries)+1 probes at most; a search answers on a match or an empty range,
// an insert after shifting up the rows above its slot; busy high until result
// synchronous active-low reset empties the table; stored data is not cleared
module sorted_name_table_search_unit #(
  parameter int TABLE_DEPTH = snts_pkg::TableDepthDef,
  parameter int NAME_BYTES  = snts_pkg::NameBytesDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_name_byte,
  input  logic                       in_name_last,
  input  logic [snts_pkg::KeyW-1:0]  in_record_key,
  output logic                       out_valid,
  output logic [snts_pkg::StatW-1:0] out_status,
  output logic [snts_pkg::KeyW-1:0]  out_found_key
);
  import snts_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int BW   = $clog2(NAME_BYTES);
  localparam int NCW  = $clog2(NAME_BYTES + 1);
  localparam logic [CW-1:0]  Depth   = CW'(TABLE_DEPTH);
  localparam logic [NCW-1:0] NBytes  = NCW'(NAME_BYTES);
  localparam logic [NCW-1:0] NLast   = NCW'(NAME_BYTES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PAD  = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_PRB  = 4'd3;
  localparam logic [3:0] S_ORD  = 4'd4;
  localparam logic [3:0] S_CMPW = 4'd5;
  localparam logic [3:0] S_KEY  = 4'd6;
  localparam logic [3:0] S_SHRD = 4'd7;
  localparam logic [3:0] S_SHWR = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]      st_r;
  logic [NCW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]   ent_r, lo_r, hx_r, mid_r, p_r;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_c;
  logic            cmd_r;
  logic [KeyW-1:0] key_r;
  logic [AW-1:0]   ord_mem [TABLE_DEPTH];
  logic [KeyW-1:0] key_mem [TABLE_DEPTH];
  logic [AW-1:0]   ord_q_r;
  logic [KeyW-1:0] key_q_r;
  logic            full;
  logic            wr_en, cmp_start;
  logic [7:0]      wr_byte;
  cmp_rsp_t        cmp_rsp;
  logic            ov_r;
  logic [StatW-1:0] ost_r;
  logic [KeyW-1:0] okey_r;

  assign full    = (ent_r == Depth);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hx_r} - 1'b1;
  assign mid_c   = mid_sum[CW:1];
  assign cnt_nxt = (cnt_r < NBytes) ? cnt_r + 1'b1 : cnt_r;

  // name byte writes: incoming beats, then zero padding
  assign wr_en     = (st_r == S_IDLE && start && cnt_r < NBytes) || st_r == S_PAD;
  assign wr_byte   = (st_r == S_PAD) ? 8'd0 : in_name_byte;
  assign cmp_start = (st_r == S_ORD);

  snts_name_cmp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_tab   (!full),
    .wr_row   (ent_r[AW-1:0]),
    .wr_idx   (cnt_r[BW-1:0]),
    .wr_byte  (wr_byte),
    .cmp_start(cmp_start),
    .cmp_row  (ord_q_r),
    .cmp_rsp  (cmp_rsp)
  );

  // order table and key memory
  always_ff @(posedge clk) begin
    if (st_r == S_PRB) ord_q_r <= ord_mem[mid_c[AW-1:0]];
    if (st_r == S_SHRD) ord_q_r <= ord_mem[p_r[AW-1:0] - 1'b1];
    if (st_r == S_SHWR) ord_mem[p_r[AW-1:0]] <= ord_q_r;
    if (st_r == S_FIN) begin
      ord_mem[lo_r[AW-1:0]] <= ent_r[AW-1:0];
      key_mem[ent_r[AW-1:0]] <= key_r;
    end
    if (st_r == S_CMPW) key_q_r <= key_mem[ord_q_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ent_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_cmd;
            key_r <= in_record_key;
            cnt_r <= cnt_nxt;
            if (in_name_last) st_r <= (cnt_nxt < NBytes) ? S_PAD : S_DISP;
          end
        end
        S_PAD: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == NLast) st_r <= S_DISP;
        end
        S_DISP: begin
          cnt_r <= '0;
          lo_r  <= '0;
          hx_r  <= ent_r;
          if (!cmd_r && full) begin
            ov_r   <= 1'b1;
            ost_r  <= ST_FULL;
            okey_r <= '0;
            st_r   <= S_IDLE;
          end else begin
            st_r <= S_PRB;
          end
        end
        S_PRB: begin
          if (lo_r < hx_r) begin
            mid_r <= mid_c;
            st_r  <= S_ORD;
          end else if (!cmd_r) begin
            p_r  <= ent_r;
            st_r <= S_SHRD;
          end else begin
            ov_r   <= 1'b1;
            ost_r  <= ST_NOT_FOUND;
            okey_r <= '0;
            st_r   <= S_IDLE;
          end
        end
        S_ORD: st_r <= S_CMPW;
        S_CMPW: begin
          if (cmp_rsp.done) begin
            if (cmd_r && !cmp_rsp.lt && !cmp_rsp.gt) begin
              st_r <= S_KEY;
            end else if (cmp_rsp.lt) begin
              hx_r <= mid_r;
              st_r <= S_PRB;
            end else begin
              lo_r <= mid_r + 1'b1;
              st_r <= S_PRB;
            end
          end
        end
        S_KEY: begin
          ov_r   <= 1'b1;
          ost_r  <= ST_FOUND;
          okey_r <= key_q_r;
          st_r   <= S_IDLE;
        end
        S_SHRD: st_r <= (p_r > lo_r) ? S_SHWR : S_FIN;
        S_SHWR: begin
          p_r  <= p_r - 1'b1;
          st_r <= S_SHRD;
        end
        S_FIN: begin
          ent_r  <= ent_r + 1'b1;
          ov_r   <= 1'b1;
          ost_r  <= ST_INSERTED;
          okey_r <= '0;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = (st_r != S_IDLE);
  assign out_valid     = ov_r;
  assign out_status    = ost_r;
  assign out_found_key = okey_r;

endmodule

// File: rtl/snts_name_cmp.sv
// name buffer, table name memory and byte serial name compare unit
module snts_name_cmp #(
  parameter int TABLE_DEPTH = snts_pkg::TableDepthDef,
  parameter int NAME_BYTES  = snts_pkg::NameBytesDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic                           wr_tab,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_row,
  input  logic [$clog2(NAME_BYTES)-1:0]  wr_idx,
  input  logic [7:0]                     wr_byte,
  input  logic                           cmp_start,
  input  logic [$clog2(TABLE_DEPTH)-1:0] cmp_row,
  output snts_pkg::cmp_rsp_t             cmp_rsp
);
  import snts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int BW = $clog2(NAME_BYTES);
  localparam logic [BW-1:0] LastIdx = BW'(NAME_BYTES - 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RD   = 2'd1;
  localparam logic [1:0] C_EV   = 2'd2;

  logic [7:0]    buf_mem [NAME_BYTES];
  logic [7:0]    tab_mem [TABLE_DEPTH][NAME_BYTES];
  logic [7:0]    buf_q_r, tab_q_r;
  logic [1:0]    st_r;
  logic [BW-1:0] k_r;
  logic [AW-1:0] row_r;
  cmp_rsp_t      rsp_r;

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_idx] <= wr_byte;
      if (wr_tab) tab_mem[wr_row][wr_idx] <= wr_byte;
    end
    if (st_r == C_RD) begin
      buf_q_r <= buf_mem[k_r];
      tab_q_r <= tab_mem[row_r][k_r];
    end
  end

  // byte serial compare: each byte is read, then evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      k_r   <= '0;
      row_r <= '0;
      rsp_r <= '0;
    end else begin
      rsp_r <= '0;
      case (st_r)
        C_IDLE: begin
          if (cmp_start) begin
            row_r <= cmp_row;
            k_r   <= '0;
            st_r  <= C_RD;
          end
        end
        C_RD: st_r <= C_EV;
        C_EV: begin
          if (buf_q_r != tab_q_r) begin
            rsp_r.done <= 1'b1;
            rsp_r.lt   <= buf_q_r < tab_q_r;
            rsp_r.gt   <= buf_q_r > tab_q_r;
            st_r       <= C_IDLE;
          end else if (buf_q_r == 8'd0 || k_r == LastIdx) begin
            rsp_r.done <= 1'b1;
            st_r       <= C_IDLE;
          end else begin
            k_r  <= k_r + 1'b1;
            st_r <= C_RD;
          end
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign cmp_rsp = rsp_r;

endmodule

// File: rtl/snts_checker.sv
// port level checks of the sorted name table search unit and their bind
module snts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_name_last,
  input logic                       out_valid,
  input logic [snts_pkg::StatW-1:0] out_status,
  input logic [snts_pkg::KeyW-1:0]  out_found_key
);
  import snts_pkg::*;

  // key is zero unless a record was found
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |-> out_found_key == '0)
    else $error("key not zero on non-found result");

  // a middle beat of a name gives no result and leaves the unit free
  a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_name_last |=> !out_valid && !busy)
    else $error("middle beat changed state");

  // the last beat of a name starts work
  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_name_last |=> busy)
    else $error("last beat did not start work");

  // one strobe per result
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result ends the work
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind sorted_name_table_search_unit snts_checker u_snts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_name_last (in_name_last),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_found_key(out_found_key)
);
